/* hdl/nearest_track_delta_r_matcher_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-track delta-R matcher.
// Both macros sample on the rising edge of aclk.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TRACK_DELTA_R_MATCHER_ASSERT_SVH
`define NEAREST_TRACK_DELTA_R_MATCHER_ASSERT_SVH

// Checked only outside reset.
`define NTDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define NTDR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hdl/ntdr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntdr_pkg
// Shared types and constants of the nearest-track delta-R matcher.
// ----------------------------------------------------------------------------
package ntdr_pkg;

    localparam int MAX_TRACKS_DEFAULT = 256;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [7:0] TYPE_TRACKER    = 8'(1 << 1);
    localparam logic [7:0] TYPE_GLOBAL     = 8'(1 << 2);
    localparam logic [7:0] MATCH_TYPE_MASK = TYPE_TRACKER | TYPE_GLOBAL;

    localparam logic signed [13:0] PHI_PI     = 14'sd3217;
    localparam logic signed [13:0] PHI_TWO_PI = 14'sd6434;

    localparam logic [25:0] DR2_SAT       = 26'h3FF_FFFF;
    localparam logic [12:0] MAX_DR_RESET  = 13'd102;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic issue;
        logic load_result;
    } ntdr_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic scan_last;
        logic pipe_busy;
    } ntdr_status_t;

endpackage

/* hdl/ntdr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntdr_ctrl
// Controller: takes input transfers, sequences the track scan of a query and
// hands finished results to the output register.
// ----------------------------------------------------------------------------
module ntdr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  ntdr_pkg::ntdr_status_t status,
    output ntdr_pkg::ntdr_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       query_accept;

    assign s_ready      = (state_reg == ST_IDLE);
    assign query_accept = s_valid && s_ready && (s_mode == ntdr_pkg::MODE_QUERY);

    always_comb begin
        cmd.accept      = s_valid && s_ready;
        cmd.scan_start  = query_accept && status.scan_needed;
        cmd.issue       = (state_reg == ST_SCAN);
        cmd.load_result = (state_reg == ST_DRAIN) && !status.pipe_busy
                          && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (query_accept) begin
                    state_next = status.scan_needed ? ST_SCAN : ST_DRAIN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (cmd.load_result) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`include "nearest_track_delta_r_matcher_assert.svh"

    `NTDR_ASSERT(a_result_from_drain, $rose(m_valid_reg) |-> $past(state_reg == ST_DRAIN), "result appeared outside drain")
    `NTDR_ASSERT(a_scan_exit, (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN || state_reg == ST_DRAIN), "scan left to a wrong state")
    `NTDR_ASSERT(a_skip_scan, (query_accept && !status.scan_needed) |=> (state_reg == ST_DRAIN), "unscanned query did not go to drain")

endmodule

/* hdl/ntdr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntdr_datapath
// Track store, match radius register, distance pipeline (read, difference and
// square registers), running best match and the result register.
// ----------------------------------------------------------------------------
module ntdr_datapath #(
    parameter int MAX_TRACKS = ntdr_pkg::MAX_TRACKS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [12:0]            cfg_wr_data,
    input  logic [1:0]             s_mode,
    input  logic signed [13:0]     s_eta,
    input  logic signed [12:0]     s_phi,
    input  logic [7:0]             s_muon_type,
    input  ntdr_pkg::ntdr_cmd_t     cmd,
    output ntdr_pkg::ntdr_status_t  status,
    output logic                   m_matched,
    output logic [7:0]             m_track_index,
    output logic [25:0]            m_dr_squared
);

    localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW = $clog2(MAX_TRACKS + 1);

    logic [13:0]        eta_mem [MAX_TRACKS];
    logic [12:0]        phi_mem [MAX_TRACKS];

    logic [12:0]        max_dr_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      wr_addr;
    logic               load_ok;
    logic [AW-1:0]      scan_addr_reg;

    logic signed [13:0] q_eta_reg;
    logic signed [12:0] q_phi_reg;

    logic               v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]      idx1_reg, idx2_reg, idx3_reg;
    logic [13:0]        rd_eta_reg;
    logic [12:0]        rd_phi_reg;

    logic signed [14:0] de_next, de_reg;
    logic signed [13:0] dp_raw, dp_next, dp_reg;
    logic signed [29:0] de_prod;
    logic signed [27:0] dp_prod;
    logic [27:0]        de_sq_reg;
    logic [26:0]        dp_sq_reg;
    logic [28:0]        d2_sum;
    logic [25:0]        d2;
    logic [25:0]        threshold;

    logic               found_reg;
    logic [25:0]        best_reg;
    logic [AW-1:0]      best_idx_reg;

    logic               m_matched_reg;
    logic [7:0]         m_track_index_reg;
    logic [25:0]        m_dr_squared_reg;

    assign wr_addr   = count_reg[AW-1:0];
    assign load_ok   = (count_reg < CW'(MAX_TRACKS));
    assign threshold = {13'd0, max_dr_reg} * {13'd0, max_dr_reg};

    always_comb begin
        status.scan_needed = ((s_muon_type & ntdr_pkg::MATCH_TYPE_MASK) != 8'd0)
                             && (count_reg != '0);
        status.scan_last   = ((CW'(scan_addr_reg) + CW'(1)) == count_reg);
        status.pipe_busy   = v1_reg || v2_reg || v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dr_reg <= ntdr_pkg::MAX_DR_RESET;
            count_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_dr_reg <= cfg_wr_data;
            end
            if (cmd.accept && s_mode == ntdr_pkg::MODE_CLEAR) begin
                count_reg <= '0;
            end else if (cmd.accept && s_mode == ntdr_pkg::MODE_LOAD && load_ok) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_mode == ntdr_pkg::MODE_LOAD && load_ok) begin
            eta_mem[wr_addr] <= s_eta;
            phi_mem[wr_addr] <= s_phi;
        end
        if (cmd.issue) begin
            rd_eta_reg <= eta_mem[scan_addr_reg];
            rd_phi_reg <= phi_mem[scan_addr_reg];
        end
    end

    always_comb begin
        de_next = {q_eta_reg[13], q_eta_reg} - {rd_eta_reg[13], rd_eta_reg};
        dp_raw  = {q_phi_reg[12], q_phi_reg} - {rd_phi_reg[12], rd_phi_reg};
        if (dp_raw > ntdr_pkg::PHI_PI) begin
            dp_next = dp_raw - ntdr_pkg::PHI_TWO_PI;
        end else if (dp_raw < -ntdr_pkg::PHI_PI) begin
            dp_next = dp_raw + ntdr_pkg::PHI_TWO_PI;
        end else begin
            dp_next = dp_raw;
        end
        de_prod = de_reg * de_reg;
        dp_prod = dp_reg * dp_reg;
        d2_sum  = {1'b0, de_sq_reg} + {2'b0, dp_sq_reg};
        d2      = (d2_sum > 29'(ntdr_pkg::DR2_SAT)) ? ntdr_pkg::DR2_SAT : d2_sum[25:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.accept && s_mode == ntdr_pkg::MODE_QUERY) begin
                found_reg <= 1'b0;
            end else if (v3_reg && d2 <= best_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_addr_reg <= '0;
        end else if (cmd.issue) begin
            scan_addr_reg <= scan_addr_reg + AW'(1);
        end
        if (cmd.accept && s_mode == ntdr_pkg::MODE_QUERY) begin
            q_eta_reg    <= s_eta;
            q_phi_reg    <= s_phi;
            best_reg     <= threshold;
            best_idx_reg <= '0;
        end else if (v3_reg && d2 <= best_reg) begin
            best_reg     <= d2;
            best_idx_reg <= idx3_reg;
        end
        idx1_reg  <= scan_addr_reg;
        idx2_reg  <= idx1_reg;
        idx3_reg  <= idx2_reg;
        de_reg    <= de_next;
        dp_reg    <= dp_next;
        de_sq_reg <= de_prod[27:0];
        dp_sq_reg <= dp_prod[26:0];
        if (cmd.load_result) begin
            m_matched_reg     <= found_reg;
            m_track_index_reg <= found_reg ? 8'(best_idx_reg) : 8'd0;
            m_dr_squared_reg  <= found_reg ? best_reg : ntdr_pkg::DR2_SAT;
        end
    end

    assign m_matched     = m_matched_reg;
    assign m_track_index = m_track_index_reg;
    assign m_dr_squared  = m_dr_squared_reg;

`include "nearest_track_delta_r_matcher_assert.svh"

    `NTDR_ASSERT_ALWAYS(a_count_bound, !aresetn || $past(!aresetn) || count_reg <= CW'(MAX_TRACKS), "track count beyond store depth")
    `NTDR_ASSERT(a_issue_in_range, cmd.issue |-> (CW'(scan_addr_reg) < count_reg), "scan read past stored tracks")
    `NTDR_ASSERT(a_match_below_sat, (cmd.load_result && found_reg) |=> (m_dr_squared_reg != ntdr_pkg::DR2_SAT), "matched result carries saturated distance")

endmodule

/* hdl/nearest_track_delta_r_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_track_delta_r_matcher
// Matches each muon to the nearest stored track in eta-phi space.
// ----------------------------------------------------------------------------
// Input transfers on s_* carry a mode: clear starts an event by emptying the
// track store, load appends one track (dropped when the store is full) and
// query asks for the nearest track to a muon. Only a query gives a result on
// m_*: a match flag, the track index and the squared distance, or unmatched
// with a saturated distance. The match radius is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this. A query scans the stored
// tracks one per cycle through a single read port of the track memory and a
// distance pipeline of read, difference and square registers; the scan is
// skipped when matching is disabled or the store is empty. The next input is
// taken in the cycle after the result is written; the block takes no new
// input while a scan runs.
// A finished result waits in the output register; while m_ready is low new
// clears and loads are still taken, and a further query waits before its
// result is written. Reset empties the store, sets the radius to 102 and
// drops any pending result; store contents are not cleared.
// ----------------------------------------------------------------------------
module nearest_track_delta_r_matcher #(
    parameter int MAX_TRACKS = ntdr_pkg::MAX_TRACKS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [12:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [13:0] s_eta,
    input  logic signed [12:0] s_phi,
    input  logic [7:0]         s_muon_type,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_matched,
    output logic [7:0]         m_track_index,
    output logic [25:0]        m_dr_squared
);

    ntdr_pkg::ntdr_cmd_t    cmd;
    ntdr_pkg::ntdr_status_t status;

    ntdr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ntdr_datapath #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_mode        (s_mode),
        .s_eta         (s_eta),
        .s_phi         (s_phi),
        .s_muon_type   (s_muon_type),
        .cmd           (cmd),
        .status        (status),
        .m_matched     (m_matched),
        .m_track_index (m_track_index),
        .m_dr_squared  (m_dr_squared)
    );

endmodule

/* sim/tb_nearest_track_delta_r_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_track_delta_r_matcher
// Self-checking testbench for the nearest-track delta-R matcher.
// ----------------------------------------------------------------------------
// A shadow of the track store and the match radius predicts the result of
// every accepted muon query; the result channel is checked against the
// oldest prediction. Directed cases cover the field extremes, ties, the
// radius edge, the phi seam, disabled matching, the ignored mode and the
// radius extremes. A full store, a long result hold-off and random events
// under several idling mixes follow.
// ----------------------------------------------------------------------------
module tb_nearest_track_delta_r_matcher;

    localparam int         MAX_TRACKS      = ntdr_pkg::MAX_TRACKS_DEFAULT;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES   = 10;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         MAX_REPORTS     = 10;

    typedef struct packed {
        logic        matched;
        logic [7:0]  track_index;
        logic [25:0] dr_squared;
    } match_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [12:0]        cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode      = ntdr_pkg::MODE_CLEAR;
    logic signed [13:0] s_eta       = '0;
    logic signed [12:0] s_phi       = '0;
    logic [7:0]         s_muon_type = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic               m_matched;
    logic [7:0]         m_track_index;
    logic [25:0]        m_dr_squared;

    logic [12:0]        radius = ntdr_pkg::MAX_DR_RESET;
    logic signed [13:0] trk_eta [MAX_TRACKS];
    logic signed [12:0] trk_phi [MAX_TRACKS];
    int                 trk_count = 0;
    match_t             pending_matches [$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_req   = 0;
    int hold_off_seen  = 0;
    int hold_left      = 0;

    nearest_track_delta_r_matcher #(
        .MAX_TRACKS(MAX_TRACKS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_eta        (s_eta),
        .s_phi        (s_phi),
        .s_muon_type  (s_muon_type),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_matched    (m_matched),
        .m_track_index(m_track_index),
        .m_dr_squared (m_dr_squared)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic match_t predict_nearest(logic signed [13:0] eta,
                                               logic signed [12:0] phi,
                                               logic [7:0] mtype);
        match_t res;
        longint best;
        longint de;
        longint dp;
        longint d2;
        int     i;
        res.matched     = 1'b0;
        res.track_index = 8'd0;
        res.dr_squared  = ntdr_pkg::DR2_SAT;
        best = longint'(radius) * longint'(radius);
        if ((mtype & ntdr_pkg::MATCH_TYPE_MASK) != 8'd0) begin
            for (i = 0; i < trk_count; i++) begin
                de = longint'(eta) - longint'(trk_eta[i]);
                dp = longint'(phi) - longint'(trk_phi[i]);
                if (dp > longint'(ntdr_pkg::PHI_PI)) begin
                    dp -= longint'(ntdr_pkg::PHI_TWO_PI);
                end else if (dp < -longint'(ntdr_pkg::PHI_PI)) begin
                    dp += longint'(ntdr_pkg::PHI_TWO_PI);
                end
                d2 = de * de + dp * dp;
                if (d2 > longint'(ntdr_pkg::DR2_SAT)) begin
                    d2 = longint'(ntdr_pkg::DR2_SAT);
                end
                if (d2 <= best) begin
                    best            = d2;
                    res.matched     = 1'b1;
                    res.track_index = 8'(i);
                    res.dr_squared  = 26'(d2);
                end
            end
        end
        return res;
    endfunction

    function automatic void apply_transfer(logic [1:0] mode, logic signed [13:0] eta,
                                           logic signed [12:0] phi, logic [7:0] mtype);
        case (mode)
            ntdr_pkg::MODE_CLEAR: begin
                trk_count = 0;
            end
            ntdr_pkg::MODE_LOAD: begin
                if (trk_count < MAX_TRACKS) begin
                    trk_eta[trk_count] = eta;
                    trk_phi[trk_count] = phi;
                    trk_count++;
                end
            end
            ntdr_pkg::MODE_QUERY: begin
                pending_matches.insert(pending_matches.size(),
                                       predict_nearest(eta, phi, mtype));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_match();
        match_t want;
        if (pending_matches.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: result with no query waiting: matched=%0b index=%0d dr2=%0d",
                         $realtime, m_matched, m_track_index, m_dr_squared);
            end
        end else begin
            want = pending_matches.pop_front();
            if (m_matched !== want.matched || m_track_index !== want.track_index ||
                m_dr_squared !== want.dr_squared) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: mismatch: expected matched=%0b index=%0d dr2=%0d, %s",
                             $realtime, want.matched, want.track_index, want.dr_squared,
                             $sformatf("got matched=%0b index=%0d dr2=%0d",
                                       m_matched, m_track_index, m_dr_squared));
                end
            end
        end
    endfunction

    // Result side: checks each transfer and drives m_ready, including the long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_match();
            end
            if (hold_off_req != hold_off_seen) begin
                hold_off_seen = hold_off_req;
                hold_left     = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic drive_item(logic [1:0] mode, logic signed [13:0] eta,
                              logic signed [12:0] phi, logic [7:0] mtype);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_eta       <= eta;
        s_phi       <= phi;
        s_muon_type <= mtype;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        apply_transfer(mode, eta, phi, mtype);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_matches.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_radius(logic [12:0] value);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        radius = value;
    endtask

    function automatic logic signed [13:0] rand_eta();
        if ($urandom_range(0, 7) == 0) begin
            return 14'($urandom_range(0, 16383));
        end
        return 14'(int'($urandom_range(0, 6000)) - 3000);
    endfunction

    function automatic logic signed [12:0] rand_phi();
        if ($urandom_range(0, 7) == 0) begin
            return 13'($urandom_range(0, 8191));
        end
        return 13'(int'($urandom_range(0, 6434)) - 3217);
    endfunction

    function automatic logic [7:0] rand_type();
        logic [7:0] t;
        t = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0, 1, 2: t = t | ntdr_pkg::TYPE_TRACKER;
            3, 4, 5: t = t | ntdr_pkg::TYPE_GLOBAL;
            6, 7:    t = t;
            default: t = t & ~ntdr_pkg::MATCH_TYPE_MASK;
        endcase
        return t;
    endfunction

    // Muon placed around a stored track, folded back across the phi seam; a random muon when the store is empty.
    task automatic drive_near_query();
        int k;
        int span;
        int e;
        int p;
        if (trk_count == 0) begin
            drive_item(ntdr_pkg::MODE_QUERY, rand_eta(), rand_phi(), rand_type());
        end else begin
            k    = $urandom_range(0, trk_count - 1);
            span = ((radius > 13'd1500) ? 1500 : int'(radius)) + 2;
            e    = int'(trk_eta[k]) + int'($urandom_range(0, 2 * span)) - span;
            p    = int'(trk_phi[k]) + int'($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 3) == 0) begin
                e = int'(trk_eta[k]);
                p = int'(trk_phi[k]);
            end
            if (p > ntdr_pkg::PHI_PI) begin
                p -= ntdr_pkg::PHI_TWO_PI;
            end else if (p < -ntdr_pkg::PHI_PI) begin
                p += ntdr_pkg::PHI_TWO_PI;
            end
            drive_item(ntdr_pkg::MODE_QUERY, 14'(e), 13'(p), rand_type());
        end
    endtask

    task automatic run_events(int n_items);
        int sent;
        int n_trk;
        int n_q;
        int j;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) != 0) begin
                drive_item(ntdr_pkg::MODE_CLEAR, rand_eta(), rand_phi(), rand_type());
                sent++;
            end
            n_trk = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 10);
            for (j = 0; j < n_trk; j++) begin
                drive_item(ntdr_pkg::MODE_LOAD, rand_eta(), rand_phi(), rand_type());
            end
            n_q = $urandom_range(1, 5);
            for (j = 0; j < n_q; j++) begin
                case ($urandom_range(0, 9))
                    0: drive_item(MODE_UNUSED, rand_eta(), rand_phi(), rand_type());
                    1: drive_item(ntdr_pkg::MODE_QUERY, rand_eta(), rand_phi(), rand_type());
                    default: drive_near_query();
                endcase
            end
            sent += n_trk + n_q;
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, logic [12:0] rad, int n_items);
        set_radius(rad);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_events(n_items);
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd0, 13'sd0, ntdr_pkg::TYPE_TRACKER);
        drive_item(ntdr_pkg::MODE_LOAD, 14'sd0, 13'sd0, 8'd0);
        drive_item(ntdr_pkg::MODE_LOAD, 14'sd0, 13'sd0, 8'hFF);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd0, 13'sd0, ntdr_pkg::TYPE_GLOBAL);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd0, 13'sd0, 8'd0);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd0, 13'sd0, ~ntdr_pkg::MATCH_TYPE_MASK);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd102, 13'sd0, ntdr_pkg::MATCH_TYPE_MASK);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd103, 13'sd0, ntdr_pkg::MATCH_TYPE_MASK);
        drive_item(MODE_UNUSED, 14'sd8191, 13'sd4095, 8'hFF);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd0, -13'sd102, ntdr_pkg::TYPE_TRACKER);
        drive_item(ntdr_pkg::MODE_CLEAR, 14'h2000, 13'h1000, 8'hFF);
        drive_item(ntdr_pkg::MODE_LOAD, 14'h2000, 13'sd4095, 8'd0);
        drive_item(ntdr_pkg::MODE_LOAD, 14'sd8191, 13'h1000, 8'd0);
        drive_item(ntdr_pkg::MODE_LOAD, 14'sd0, 13'sd3217, 8'd0);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd0, -13'sd3217, ntdr_pkg::TYPE_TRACKER);
        set_radius(13'h1FFF);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd8191, 13'sd4095, ntdr_pkg::TYPE_GLOBAL);
        drive_item(ntdr_pkg::MODE_QUERY, 14'h2000, 13'h1000, 8'hFF);
        set_radius(13'd0);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd0, 13'sd3217, ntdr_pkg::TYPE_TRACKER);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd1, 13'sd3217, ntdr_pkg::TYPE_TRACKER);
        drive_item(ntdr_pkg::MODE_CLEAR, 14'sd0, 13'sd0, 8'd0);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd0, 13'sd3217, ntdr_pkg::MATCH_TYPE_MASK);
        set_radius(ntdr_pkg::MAX_DR_RESET);
    endtask

    task automatic test_store_full();
        int j;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_radius(13'd200);
        drive_item(ntdr_pkg::MODE_CLEAR, rand_eta(), rand_phi(), rand_type());
        for (j = 0; j < MAX_TRACKS; j++) begin
            drive_item(ntdr_pkg::MODE_LOAD, rand_eta(), rand_phi(), rand_type());
        end
        drive_item(ntdr_pkg::MODE_LOAD, 14'sd1234, -13'sd1234, 8'd0);
        drive_item(ntdr_pkg::MODE_LOAD, 14'sd1234, -13'sd1234, 8'd0);
        drive_item(ntdr_pkg::MODE_QUERY, trk_eta[MAX_TRACKS - 1], trk_phi[MAX_TRACKS - 1],
                   ntdr_pkg::TYPE_TRACKER);
        drive_item(ntdr_pkg::MODE_QUERY, 14'sd1234, -13'sd1234, ntdr_pkg::TYPE_GLOBAL);
        drive_near_query();
        drive_near_query();
    endtask

    task automatic test_backpressure();
        int j;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_radius(13'd500);
        hold_off_req++;
        drive_item(ntdr_pkg::MODE_CLEAR, rand_eta(), rand_phi(), rand_type());
        for (j = 0; j < 8; j++) begin
            drive_item(ntdr_pkg::MODE_LOAD, rand_eta(), rand_phi(), rand_type());
        end
        for (j = 0; j < 10; j++) begin
            drive_near_query();
            drive_item(ntdr_pkg::MODE_LOAD, rand_eta(), rand_phi(), rand_type());
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 13'd102, 300);
        run_phase(86, 0, 13'($urandom_range(1, 400)), 300);
        run_phase(0, 86, 13'h1FFF, 300);
        run_phase(10, 10, 13'd0, 150);
        run_phase(10, 10, 13'($urandom_range(0, 8191)), 150);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_store_full();
        test_backpressure();
        test_random_traffic();
        wait_drain();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_matches.size() == 0) begin
            $display("PASS nearest_track_delta_r_matcher");
        end else begin
            $display("FAIL nearest_track_delta_r_matcher");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAIL nearest_track_delta_r_matcher");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/ntdr_pkg.sv
hdl/ntdr_ctrl.sv
hdl/ntdr_datapath.sv
hdl/nearest_track_delta_r_matcher.sv
sim/tb_nearest_track_delta_r_matcher.sv
